>>> rtl/planar_pose_compose_difference_macros.svh
// Assertion macros for the pose pipeline
`ifndef PLANAR_POSE_COMPOSE_DIFFERENCE_MACROS_SVH
`define PLANAR_POSE_COMPOSE_DIFFERENCE_MACROS_SVH
`ifndef SYNTHESIS
`define PPCD_ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define PPCD_ASSERT_RESET(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("reset check failed");
`else
`define PPCD_ASSERT_IMPL(label, clk, rst_n, prop)
`define PPCD_ASSERT_RESET(label, clk, prop)
`endif
`endif

>>> rtl/ppcd_pkg.sv
package ppcd_pkg;
  localparam int CordicStagesDef = 20;
  localparam int AtanEntries = 30;
  localparam logic signed [33:0] PiQ = 34'sd210828714;
  localparam logic signed [33:0] TwoPiQ = 34'sd421657428;
  localparam logic signed [33:0] HalfPiQ = 34'sd105414357;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  typedef enum logic {
    MODE_COMPOSE = 1'b0,
    MODE_DIFF = 1'b1
  } mode_t;

  typedef struct packed {
    logic mode;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_heading;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_heading;
  } pose_in_t;

  typedef struct packed {
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_heading;
    logic overflow;
  } pose_out_t;

  function automatic logic signed [33:0] atan_q30(input int i);
    logic signed [33:0] t;
    begin
      case (i)
        0: t = 34'sd843314856;
        1: t = 34'sd497837829;
        2: t = 34'sd263043836;
        3: t = 34'sd133525158;
        4: t = 34'sd67021686;
        5: t = 34'sd33543515;
        6: t = 34'sd16775850;
        7: t = 34'sd8388437;
        8: t = 34'sd4194282;
        9: t = 34'sd2097149;
        10: t = 34'sd1048575;
        11: t = 34'sd524287;
        12: t = 34'sd262143;
        13: t = 34'sd131071;
        14: t = 34'sd65535;
        15: t = 34'sd32767;
        16: t = 34'sd16383;
        17: t = 34'sd8191;
        18: t = 34'sd4095;
        19: t = 34'sd2047;
        20: t = 34'sd1023;
        21: t = 34'sd511;
        22: t = 34'sd255;
        23: t = 34'sd127;
        24: t = 34'sd63;
        25: t = 34'sd31;
        26: t = 34'sd15;
        27: t = 34'sd7;
        28: t = 34'sd3;
        29: t = 34'sd1;
        default: t = 34'sd0;
      endcase
      return t;
    end
  endfunction
endpackage

>>> rtl/ppcd_stream_if.sv
interface ppcd_stream_if #(parameter type payload_t = logic) ();
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/planar_pose_compose_difference.sv
// Pose compose/difference pipeline, one item per cycle sustained while downstream is ready.
// CORDIC_STAGES is capped at 30 (AtanEntries) rotation stages.
// Stages: 3 angle-wrap steps, reduce, CORDIC_STAGES rotations, 1 multiply,
// 1 sum, 1 round/saturate; all stages advance together on downstream ready.
// Reset (rst_n low, synchronous) clears every valid bit; payload is not reset.
module planar_pose_compose_difference
  import ppcd_pkg::*;
#(
  parameter int CORDIC_STAGES = CordicStagesDef
) (
  input logic clk,
  input logic rst_n,
  ppcd_stream_if.sink in_ch,
  ppcd_stream_if.source out_ch
);
`include "planar_pose_compose_difference_macros.svh"
  localparam int NRun = (CORDIC_STAGES < AtanEntries) ? CORDIC_STAGES : AtanEntries;
  localparam int NSt = NRun + 7;

  // wrap uses 34-bit remainder-free reduction: add or subtract multiples of 2pi in steps
  typedef struct packed {
    logic mode;
    logic signed [31:0] a_x, a_y, a_heading, b_x, b_y, b_heading;
    logic signed [33:0] w;  // angle being wrapped / reduced
    logic signed [33:0] hd; // heading difference being wrapped
    logic neg;
    logic signed [33:0] cx, cy, cz;
  } ctx_t;

  logic adv;
  logic [NSt-1:0] v_r;
  assign adv = out_ch.ready || !v_r[NSt-1];
  assign in_ch.ready = adv;

  // coarse wrap step: value v (<= 34 bits signed) -> subtract 2pi*2^sh if v >= it, add it if v < -(2pi*2^sh)
  function automatic logic signed [33:0] wstep(input logic signed [33:0] v,
                                              input int sh);
    logic signed [33:0] m;
    begin
      m = TwoPiQ <<< sh;
      if (v >= m) wstep = v - m;
      else if (v < -m) wstep = v + m;
      else wstep = v;
    end
  endfunction

  function automatic logic signed [33:0] wfinal(input logic signed [33:0] v);
    logic signed [33:0] r;
    begin
      r = v;
      if (r < 0) r = r + TwoPiQ;
      if (r >= TwoPiQ) r = r - TwoPiQ;
      if (r > PiQ) r = r - TwoPiQ;
      wfinal = r;
    end
  endfunction

  function automatic ctx_t wrap_two(input ctx_t c, input int s1, input int s0);
    ctx_t t;
    begin
      t = c;
      t.w = wstep(wstep(c.w, s1), s0);
      t.hd = wstep(wstep(c.hd, s1), s0);
      wrap_two = t;
    end
  endfunction

  function automatic ctx_t wrap_last(input ctx_t c);
    ctx_t t;
    begin
      t = c;
      t.w = wfinal(wstep(c.w, 0));
      t.hd = wfinal(wstep(c.hd, 0));
      wrap_last = t;
    end
  endfunction

  function automatic ctx_t reduce_load(input ctx_t c);
    ctx_t t;
    begin
      t = c;
      t.cx = CordicGain;
      t.cy = '0;
      if (c.w > HalfPiQ) begin
        t.neg = 1'b1; t.cz = (c.w - PiQ) <<< 4;
      end else if (c.w < -HalfPiQ) begin
        t.neg = 1'b1; t.cz = (c.w + PiQ) <<< 4;
      end else begin
        t.neg = 1'b0; t.cz = c.w <<< 4;
      end
      reduce_load = t;
    end
  endfunction

  function automatic ctx_t cordic_rot(input ctx_t c, input int i);
    ctx_t t;
    begin
      t = c;
      if (!c.cz[33]) begin
        t.cx = c.cx - (c.cy >>> i);
        t.cy = c.cy + (c.cx >>> i);
        t.cz = c.cz - atan_q30(i);
      end else begin
        t.cx = c.cx + (c.cy >>> i);
        t.cy = c.cy - (c.cx >>> i);
        t.cz = c.cz + atan_q30(i);
      end
      cordic_rot = t;
    end
  endfunction

  ctx_t c_r [0:NRun+3];
  logic signed [63:0] p0_r, p1_r, p2_r, p3_r;
  logic signed [33:0] b0_r, b1_r;
  logic signed [31:0] hs_r;
  logic hso_r;
  logic signed [33:0] hw_r;
  logic md_r;
  logic signed [65:0] sx_r, sy_r;
  logic signed [31:0] hs2_r;
  logic hso2_r, md2_r;
  logic signed [33:0] hw2_r;
  pose_out_t o_r;
  pose_out_t o_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (adv) v_r <= {v_r[NSt-2:0], in_ch.valid};
  end

  ctx_t c0;
  always_comb begin
    c0 = '0;
    c0.mode = in_ch.data.mode;
    c0.a_x = in_ch.data.a_x; c0.a_y = in_ch.data.a_y;
    c0.a_heading = in_ch.data.a_heading;
    c0.b_x = in_ch.data.b_x; c0.b_y = in_ch.data.b_y;
    c0.b_heading = in_ch.data.b_heading;
    c0.w = (in_ch.data.mode == MODE_DIFF) ? 34'(in_ch.data.b_heading)
                                           : 34'(in_ch.data.a_heading);
    c0.hd = 34'(in_ch.data.a_heading) - 34'(in_ch.data.b_heading);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // wrap stages: |v| < 2^33 ; 2pi*2^k for k=4..0
      c_r[0] <= wrap_two(c0, 4, 3);
      c_r[1] <= wrap_two(c_r[0], 2, 1);
      c_r[2] <= wrap_last(c_r[1]);
      // range reduce and load CORDIC
      c_r[3] <= reduce_load(c_r[2]);
    end
  end

  for (genvar i = 0; i < NRun; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (adv) c_r[i+4] <= cordic_rot(c_r[i+3], i);
    end
  end

  ctx_t ce;
  logic signed [31:0] cs, sn;
  logic signed [32:0] ox, oy;
  logic signed [32:0] hsum;
  always_comb begin
    ce = c_r[NRun+3];
    cs = ce.neg ? 32'(-ce.cx) : 32'(ce.cx);
    sn = ce.neg ? 32'(-ce.cy) : 32'(ce.cy);
    if (ce.mode == MODE_DIFF) begin
      ox = 33'(ce.a_x) - 33'(ce.b_x);
      oy = 33'(ce.a_y) - 33'(ce.b_y);
    end else begin
      ox = 33'(ce.b_x);
      oy = 33'(ce.b_y);
    end
    hsum = 33'(ce.a_heading) + 33'(ce.b_heading);
  end

  // multiply stage: 33x32 products
  always_ff @(posedge clk) begin
    if (adv) begin
      p0_r <= 64'(ox * cs);
      p1_r <= 64'(oy * sn);
      p2_r <= 64'(ox * sn);
      p3_r <= 64'(oy * cs);
      b0_r <= 34'(ce.a_x);
      b1_r <= 34'(ce.a_y);
      md_r <= ce.mode;
      hw_r <= ce.hd;
      hso_r <= (hsum > 33'sd2147483647) || (hsum < -33'sd2147483648);
      hs_r <= hsum[32] ? ((hsum < -33'sd2147483648) ? 32'h80000000 : hsum[31:0])
                       : ((hsum > 33'sd2147483647) ? 32'h7fffffff : hsum[31:0]);
    end
  end

  // sum stage
  always_ff @(posedge clk) begin
    if (adv) begin
      if (md_r == MODE_DIFF) begin
        sx_r <= 66'(p0_r) + 66'(p1_r) + 66'sd536870912;
        sy_r <= 66'(p3_r) - 66'(p2_r) + 66'sd536870912;
      end else begin
        sx_r <= 66'(p0_r) - 66'(p1_r) + (66'(b0_r) <<< 30) + 66'sd536870912;
        sy_r <= 66'(p2_r) + 66'(p3_r) + (66'(b1_r) <<< 30) + 66'sd536870912;
      end
      md2_r <= md_r; hw2_r <= hw_r; hs2_r <= hs_r; hso2_r <= hso_r;
    end
  end

  logic signed [35:0] qx, qy;
  logic ofx, ofy;
  assign qx = sx_r[65:30];
  assign qy = sy_r[65:30];
  assign ofx = (qx > 36'sd2147483647) || (qx < -36'sd2147483648);
  assign ofy = (qy > 36'sd2147483647) || (qy < -36'sd2147483648);

  always_comb begin
    o_nxt.r_x = ofx ? (qx[35] ? 32'h80000000 : 32'h7fffffff) : qx[31:0];
    o_nxt.r_y = ofy ? (qy[35] ? 32'h80000000 : 32'h7fffffff) : qy[31:0];
    o_nxt.r_heading = (md2_r == MODE_DIFF) ? hw2_r[31:0] : hs2_r;
    o_nxt.overflow = ofx || ofy || ((md2_r == MODE_COMPOSE) && hso2_r);
  end

  always_ff @(posedge clk) begin
    if (adv) o_r <= o_nxt;
  end

  assign out_ch.valid = v_r[NSt-1];
  assign out_ch.data = o_r;

  `PPCD_ASSERT_IMPL(a_stall_hold, clk, rst_n,
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid && $stable(out_ch.data))
  `PPCD_ASSERT_IMPL(a_ready_when_empty, clk, rst_n,
    !out_ch.valid |-> in_ch.ready)
  `PPCD_ASSERT_RESET(a_reset_clear, clk, !rst_n |=> !out_ch.valid)
endmodule
